// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the radix symbol converter.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SIRS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sirs: assertion failed");

// Condition that must never be true outside reset.
`define SIRS_NEVER(label, expr) \
    `SIRS_ASSERT(label, !(expr))

`endif

// ===== sv/sirs_pkg.sv =====
// Package of the radix symbol converter: widths, codes, shared types and
// the symbol table lookup. No dependencies.
package sirs_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_SYMBOLS = 16;
    localparam int CNT_W       = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W      = $clog2(VALUE_BITS);
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
    localparam int SYM_W       = 8;
    localparam int TABLE_W     = 64;
    localparam int REG_IDX_W   = 2;

    localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;

    localparam logic [RADIX_W-1:0] RADIX_RESET    = 5'd10;
    localparam logic [TABLE_W-1:0] SYM_LOW_RESET  = 64'h3736_3534_3332_3130;
    localparam logic [TABLE_W-1:0] SYM_HIGH_RESET = 64'h0000_0000_0000_3938;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic                  start;
        logic [RADIX_W-1:0]    divisor;
        logic [VALUE_BITS-1:0] dividend;
    } div_ctrl_t;

    // Status and results from the divider.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [RADIX_W-1:0]    remainder;
    } div_stat_t;

    // Symbol byte for a digit value; the two table words form one table.
    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [DIGIT_W-1:0] digit,
        input logic [TABLE_W-1:0] sym_low,
        input logic [TABLE_W-1:0] sym_high
    );
        logic [2*TABLE_W-1:0] tbl;
        tbl = {sym_high, sym_low};
        return tbl[{digit, 3'b000} +: SYM_W];
    endfunction

endpackage

// ===== sv/sirs_if.sv =====
// Stream interfaces of the radix symbol converter: signed values in,
// symbol bytes out. Depends on sirs_pkg.
interface sirs_value_if;
    import sirs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sirs_symbol_if;
    import sirs_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             bad_table;

    modport source (output valid, output symbol, output last, output bad_table,
                    input ready);
    modport sink   (input valid, input symbol, input last, input bad_table,
                    output ready);
endinterface

// ===== sv/sirs_divider.sv =====
// Restoring divider of the radix symbol converter: one quotient bit per cycle.
// Depends on sirs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sirs_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  sirs_pkg::div_ctrl_t ctrl,
    output sirs_pkg::div_stat_t stat
);
    import sirs_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    divisor_reg, divisor_next;

    logic [RADIX_W:0]      trial;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and subtract.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (ctrl.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            quo_next     = ctrl.dividend;
            rem_next     = '0;
            divisor_next = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? RADIX_W'(trial - {1'b0, divisor_reg}) : trial[RADIX_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ADDR_W'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

    `SIRS_ASSERT(a_start_runs, ctrl.start |=> busy_reg)
    `SIRS_ASSERT(a_rem_below_divisor,
        busy_reg && divisor_reg != '0 |-> rem_reg < divisor_reg)
    `SIRS_ASSERT(a_done_after_run, done_reg |-> !busy_reg && $past(busy_reg))

endmodule

// ===== sv/signed_integer_to_radix_symbols_top.sv =====
// Top level of the radix symbol converter: sequencer, table check, digit
// store and output register. Depends on sirs_pkg, sirs_if, sirs_divider and assert_macros.svh.
//
// Usage: a signed 32-bit value arrives on the values channel and leaves as
// a run of symbol bytes on the symbols channel, most significant digit first,
// with a leading minus sign for a negative value and last set on the final
// byte. If the configured table is invalid (radix outside two to sixteen, a
// plus or minus symbol in use, or a repeated symbol) the run is one transfer
// with symbol zero, last and bad_table set.
// Timing: the block takes one value at a time and is not ready until the
// last byte of the run has been loaded into the output register. The table
// check tests one symbol per cycle against plus, minus and all later ones.
// Each digit then comes from the shared restoring divider, which produces
// one quotient bit per cycle; a value has 32 digits at most (radix two).
// Emission steps through the sign, if any, then for each digit a fetch
// from the digit store and a put into the output register.
// Stalls: the output register holds its byte while ready is low and the
// sequencer waits; nothing is lost or repeated.
// Reset: the registers return to radix ten and the table "0123456789"; the
// digit store is not cleared, since every digit is written before it is read.
// Configuration writes are taken at any edge with write_enable high and are
// meant to arrive only while the block is idle.
`include "assert_macros.svh"

module signed_integer_to_radix_symbols_top (
    input  logic                              clk,
    input  logic                              rst_n,
    sirs_value_if.sink                        values,
    sirs_symbol_if.source                     symbols,
    input  logic                              write_enable,
    input  logic [sirs_pkg::REG_IDX_W-1:0]    reg_index,
    input  logic [sirs_pkg::TABLE_W-1:0]      write_data
);
    import sirs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CHECK     = 8'b0000_0010,
        S_BAD       = 8'b0000_0100,
        S_DIV_START = 8'b0000_1000,
        S_DIV_WAIT  = 8'b0001_0000,
        S_SIGN      = 8'b0010_0000,
        S_FETCH     = 8'b0100_0000,
        S_PUT       = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;

    // Configuration registers.
    logic [RADIX_W-1:0]    radix_reg;
    logic [TABLE_W-1:0]    sym_low_reg;
    logic [TABLE_W-1:0]    sym_high_reg;

    // Conversion state.
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]      digit_count_reg, digit_count_next;
    logic [DIGIT_W-1:0]    chk_idx_reg, chk_idx_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]      out_sym_reg, out_sym_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_bad_reg, out_bad_next;

    // Digit store, least significant digit at address zero.
    logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];
    logic [DIGIT_W-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;

    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;

    logic                  slot_free;
    logic                  radix_bad;
    logic                  sym_bad;
    logic [SYM_W-1:0]      chk_sym;
    logic [DIGIT_W-1:0]    last_idx;
    logic [VALUE_BITS-1:0] raw_value;
    logic [CNT_W-1:0]      count_inc;

    sirs_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    // The output register can take a byte when empty or being drained.
    assign slot_free = !out_valid_reg || symbols.ready;

    // Table check: symbol chk_idx against plus, minus and every later
    // symbol in use, one symbol per cycle.
    assign radix_bad = (radix_reg < RADIX_W'(2)) || (radix_reg > RADIX_W'(MAX_SYMBOLS));
    assign last_idx  = DIGIT_W'(radix_reg - 1'b1);
    assign chk_sym   = symbol_at(chk_idx_reg, sym_low_reg, sym_high_reg);

    always_comb
    begin
        sym_bad = (chk_sym == MINUS_SYM) || (chk_sym == PLUS_SYM);
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((RADIX_W'(j) > RADIX_W'(chk_idx_reg)) && (RADIX_W'(j) < radix_reg) &&
                (symbol_at(DIGIT_W'(j), sym_low_reg, sym_high_reg) == chk_sym))
            begin
                sym_bad = 1'b1;
            end
        end
    end

    assign raw_value = values.value;
    assign count_inc = digit_count_reg + 1'b1;
    assign rd_addr   = ADDR_W'(digit_count_reg - 1'b1);

    assign div_ctrl.start    = (state_reg == S_DIV_START);
    assign div_ctrl.divisor  = radix_reg;
    assign div_ctrl.dividend = mag_reg;

    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        digit_count_next = digit_count_reg;
        chk_idx_next     = chk_idx_reg;
        out_valid_next   = out_valid_reg && !symbols.ready;
        out_sym_next     = out_sym_reg;
        out_last_next    = out_last_reg;
        out_bad_next     = out_bad_reg;
        wr_en            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (values.valid)
                begin
                    neg_next         = raw_value[VALUE_BITS-1];
                    mag_next         = raw_value[VALUE_BITS-1] ? (~raw_value + 1'b1)
                                                               : raw_value;
                    digit_count_next = '0;
                    chk_idx_next     = '0;
                    state_next       = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (radix_bad || sym_bad)
                begin
                    state_next = S_BAD;
                end
                else if (chk_idx_reg == last_idx)
                begin
                    state_next = S_DIV_START;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            S_BAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = '0;
                    out_last_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    wr_en            = 1'b1;
                    mag_next         = div_stat.quotient;
                    digit_count_next = count_inc;
                    if ((div_stat.quotient == '0) || (count_inc == CNT_W'(VALUE_BITS)))
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_FETCH;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = MINUS_SYM;
                    out_last_next  = 1'b0;
                    out_bad_next   = 1'b0;
                    state_next     = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // The digit store read is registered; the digit is ready next cycle.
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_sym_next     = symbol_at(rd_data_reg, sym_low_reg, sym_high_reg);
                    out_last_next    = (digit_count_reg == CNT_W'(1));
                    out_bad_next     = 1'b0;
                    digit_count_next = digit_count_reg - 1'b1;
                    state_next       = (digit_count_reg == CNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            neg_reg         <= 1'b0;
            digit_count_reg <= '0;
            chk_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            radix_reg       <= RADIX_RESET;
            sym_low_reg     <= SYM_LOW_RESET;
            sym_high_reg    <= SYM_HIGH_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            neg_reg         <= neg_next;
            digit_count_reg <= digit_count_next;
            chk_idx_reg     <= chk_idx_next;
            out_valid_reg   <= out_valid_next;
            if (write_enable)
            begin
                case (reg_index)
                    REG_RADIX:    radix_reg    <= write_data[RADIX_W-1:0];
                    REG_SYM_LOW:  sym_low_reg  <= write_data;
                    REG_SYM_HIGH: sym_high_reg <= write_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    // Digit store: one write port from the divider, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[digit_count_reg[ADDR_W-1:0]] <= div_stat.remainder[DIGIT_W-1:0];
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign values.ready      = (state_reg == S_IDLE);
    assign symbols.valid     = out_valid_reg;
    assign symbols.symbol    = out_sym_reg;
    assign symbols.last      = out_last_reg;
    assign symbols.bad_table = out_bad_reg;

    `SIRS_NEVER(a_count_bound, digit_count_reg > CNT_W'(VALUE_BITS))
    `SIRS_ASSERT(a_start_when_free, div_ctrl.start |-> !div_stat.busy)
    `SIRS_ASSERT(a_error_form,
        out_valid_reg && out_bad_reg |-> out_last_reg && out_sym_reg == '0)
    `SIRS_ASSERT(a_emit_has_digit, state_reg == S_PUT |-> digit_count_reg != '0)

endmodule
